// File: design/mlfqs_pkg.sv
// Shared types and constants for the multilevel feedback queue scheduler.
package mlfqs_pkg;

  localparam logic [2:0] OP_CREATE  = 3'd0;
  localparam logic [2:0] OP_UNBLOCK = 3'd1;
  localparam logic [2:0] OP_YIELD   = 3'd2;
  localparam logic [2:0] OP_BLOCK   = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  localparam logic [1:0] CFG_MLFQ_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_SLICE_TICKS  = 2'd1;
  localparam logic [1:0] CFG_BOOST_PERIOD = 2'd2;

  localparam int          CFG_DATA_W       = 16;
  localparam int          QNT_W            = 6;
  localparam logic [3:0]  SLICE_MAX        = 4'd15;
  localparam logic [3:0]  SLICE_RESET      = 4'd4;
  localparam logic [15:0] BOOST_RESET      = 16'd1000;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] thread_id;
    logic [4:0] start_level;
  } in_item_t;

  typedef struct packed {
    logic [3:0] next_thread;
    logic       run_idle;
    logic       preempt;
    logic       demoted;
    logic       boosted;
  } out_item_t;

  // field write enables of the thread table
  typedef struct packed {
    logic level;
    logic quantum;
    logic link;
  } twe_t;

  // field write enables of the queue table
  typedef struct packed {
    logic head;
    logic tail;
  } qwe_t;

endpackage

// File: design/mlfqs_tmem.sv
// Thread table memory: level, used quantum and queue link per thread.
module mlfqs_tmem #(
  parameter int NUM_THREADS = 16,
  parameter int NUM_LEVELS  = 20
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [$clog2(NUM_THREADS)-1:0] rd_addr,
  output logic [$clog2(NUM_LEVELS)-1:0]  rd_level,
  output logic [mlfqs_pkg::QNT_W-1:0]    rd_quantum,
  output logic [$clog2(NUM_THREADS)-1:0] rd_link,
  input  mlfqs_pkg::twe_t                we,
  input  logic [$clog2(NUM_THREADS)-1:0] wr_addr,
  input  logic [$clog2(NUM_LEVELS)-1:0]  wr_level,
  input  logic [mlfqs_pkg::QNT_W-1:0]    wr_quantum,
  input  logic [$clog2(NUM_THREADS)-1:0] wr_link
);
  import mlfqs_pkg::*;

  localparam int TW = $clog2(NUM_THREADS);
  localparam int LW = $clog2(NUM_LEVELS);

  logic [LW-1:0]    level_mem   [NUM_THREADS];
  logic [QNT_W-1:0] quantum_mem [NUM_THREADS];
  logic [TW-1:0]    link_mem    [NUM_THREADS];

  always_ff @(posedge clk) begin
    if (we.level)   level_mem[wr_addr]   <= wr_level;
    if (we.quantum) quantum_mem[wr_addr] <= wr_quantum;
    if (we.link)    link_mem[wr_addr]    <= wr_link;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_level   <= level_mem[rd_addr];
      rd_quantum <= quantum_mem[rd_addr];
      rd_link    <= link_mem[rd_addr];
    end
  end

endmodule

// File: design/mlfqs_qmem.sv
// Queue table memory: head and tail thread of each level's ready queue.
module mlfqs_qmem #(
  parameter int NUM_THREADS = 16,
  parameter int NUM_LEVELS  = 20
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [$clog2(NUM_LEVELS)-1:0]  rd_addr,
  output logic [$clog2(NUM_THREADS)-1:0] rd_head,
  output logic [$clog2(NUM_THREADS)-1:0] rd_tail,
  input  mlfqs_pkg::qwe_t                we,
  input  logic [$clog2(NUM_LEVELS)-1:0]  wr_addr,
  input  logic [$clog2(NUM_THREADS)-1:0] wr_head,
  input  logic [$clog2(NUM_THREADS)-1:0] wr_tail
);
  import mlfqs_pkg::*;

  localparam int TW = $clog2(NUM_THREADS);

  logic [TW-1:0] head_mem [NUM_LEVELS];
  logic [TW-1:0] tail_mem [NUM_LEVELS];

  always_ff @(posedge clk) begin
    if (we.head) head_mem[wr_addr] <= wr_head;
    if (we.tail) tail_mem[wr_addr] <= wr_tail;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_head <= head_mem[rd_addr];
      rd_tail <= tail_mem[rd_addr];
    end
  end

endmodule

// File: design/mlfq_thread_scheduler.sv
// Multilevel feedback queue scheduler: sequencer over thread and queue tables.
//
// One operation is taken at a time and gives one result. A tick that ends
// the boost period also walks every lower level, splicing its queue behind
// the top queue, and then sweeps every thread back to the top level. The
// sequencer works through the single read port of each of the two tables,
// reading then writing back one entry per step. A result waits in the
// output register, and the next operation may be taken meanwhile.
module mlfq_thread_scheduler #(
  parameter int NUM_THREADS = 16,
  parameter int NUM_LEVELS  = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mlfqs_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mlfqs_pkg::out_item_t                out_data,
  input  logic                                cfg_wr_en,
  input  logic [1:0]                          cfg_index,
  input  logic [mlfqs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mlfqs_pkg::*;

  localparam int TW  = $clog2(NUM_THREADS);
  localparam int LW  = $clog2(NUM_LEVELS);
  localparam int QCW = LW + 5;
  localparam logic [LW-1:0] TOP = LW'(NUM_LEVELS - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LVL    = 4'd1;
  localparam logic [3:0] S_ENQ    = 4'd2;
  localparam logic [3:0] S_DISP   = 4'd3;
  localparam logic [3:0] S_DP1    = 4'd4;
  localparam logic [3:0] S_DP2    = 4'd5;
  localparam logic [3:0] S_TICK   = 4'd6;
  localparam logic [3:0] S_BST    = 4'd7;
  localparam logic [3:0] S_BSTA   = 4'd8;
  localparam logic [3:0] S_BSTRD  = 4'd9;
  localparam logic [3:0] S_BSTWR  = 4'd10;
  localparam logic [3:0] S_BSTEND = 4'd11;
  localparam logic [3:0] S_SWEEP  = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0]  state;
  logic        mlfq_enable;
  logic [3:0]  slice_ticks;
  logic [15:0] boost_period;

  logic                   running_valid;
  logic [TW-1:0]          running_id;
  logic [3:0]             slice_count;
  logic [15:0]            boost_count;
  logic [NUM_THREADS-1:0] qvalid;
  logic [NUM_THREADS-1:0] in_ready;
  logic [NUM_LEVELS-1:0]  nonempty;

  logic [TW-1:0] enq_t;
  logic [LW-1:0] enq_q;
  logic          after_disp;
  logic          do_boost;
  logic          preempt_r, demoted_r, boosted_r;
  logic [LW-1:0] dq;
  logic [TW-1:0] disp_t;
  logic [LW-1:0] bq;
  logic [TW-1:0] th, tt;
  logic          tne;
  logic [TW-1:0] sweep;

  // thread table port
  logic             t_rd_en;
  logic [TW-1:0]    t_rd_addr;
  logic [LW-1:0]    t_rd_level;
  logic [QNT_W-1:0] t_rd_quantum;
  logic [TW-1:0]    t_rd_link;
  twe_t             t_we;
  logic [TW-1:0]    t_wr_addr;
  logic [LW-1:0]    t_wr_level;
  logic [QNT_W-1:0] t_wr_quantum;
  logic [TW-1:0]    t_wr_link;

  // queue table port
  logic          q_rd_en;
  logic [LW-1:0] q_rd_addr;
  logic [TW-1:0] q_rd_head, q_rd_tail;
  qwe_t          q_we;
  logic [LW-1:0] q_wr_addr;
  logic [TW-1:0] q_wr_head, q_wr_tail;

  mlfqs_tmem #(.NUM_THREADS(NUM_THREADS), .NUM_LEVELS(NUM_LEVELS)) u_tmem (
    .clk(clk), .rd_en(t_rd_en), .rd_addr(t_rd_addr),
    .rd_level(t_rd_level), .rd_quantum(t_rd_quantum), .rd_link(t_rd_link),
    .we(t_we), .wr_addr(t_wr_addr), .wr_level(t_wr_level),
    .wr_quantum(t_wr_quantum), .wr_link(t_wr_link)
  );

  mlfqs_qmem #(.NUM_THREADS(NUM_THREADS), .NUM_LEVELS(NUM_LEVELS)) u_qmem (
    .clk(clk), .rd_en(q_rd_en), .rd_addr(q_rd_addr),
    .rd_head(q_rd_head), .rd_tail(q_rd_tail),
    .we(q_we), .wr_addr(q_wr_addr), .wr_head(q_wr_head), .wr_tail(q_wr_tail)
  );

  // decode of the incoming item
  logic          acc;
  logic [TW-1:0] tid;
  logic          tid_ok;
  logic [LW-1:0] lvl_sat;
  logic          can_queue;
  logic [LW-1:0] home_new;
  logic [LW-1:0] home_rd;

  assign in_stall  = (state != S_IDLE);
  assign acc       = in_valid && !in_stall;
  assign tid       = TW'(in_data.thread_id);
  assign tid_ok    = (int'(in_data.thread_id) < NUM_THREADS);
  assign lvl_sat   = (int'(in_data.start_level) > NUM_LEVELS - 1) ? TOP
                                                                  : LW'(in_data.start_level);
  assign can_queue = tid_ok && !in_ready[tid] && !(running_valid && running_id == tid);
  assign home_new  = mlfq_enable ? lvl_sat : TOP;
  assign home_rd   = mlfq_enable ? t_rd_level : TOP;

  // highest non-empty queue, top only in round-robin mode
  logic          disp_found;
  logic [LW-1:0] disp_q;
  always_comb begin
    disp_found = 1'b0;
    disp_q     = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (nonempty[i] && (mlfq_enable || i == NUM_LEVELS - 1)) begin
        disp_found = 1'b1;
        disp_q     = LW'(i);
      end
    end
  end

  // tick charge of the running thread
  logic [QNT_W-1:0] qnt_cur, qnt_inc;
  logic [QCW-1:0]   quantum;
  logic             exhausted;
  assign qnt_cur   = qvalid[running_id] ? t_rd_quantum : '0;
  assign qnt_inc   = qnt_cur + QNT_W'(1);
  assign quantum   = QCW'(TOP) - QCW'(t_rd_level) + QCW'(slice_ticks);
  assign exhausted = QCW'(qnt_inc) >= quantum;

  logic [3:0]  slice_inc;
  logic [15:0] boost_inc;
  assign slice_inc = (slice_count < SLICE_MAX) ? slice_count + 4'd1 : slice_count;
  assign boost_inc = boost_count + 16'd1;

  // memory commands per step
  always_comb begin
    t_rd_en      = 1'b0;
    t_rd_addr    = running_id;
    t_we         = '0;
    t_wr_addr    = tt;
    t_wr_level   = TOP;
    t_wr_quantum = '0;
    t_wr_link    = enq_t;
    q_rd_en      = 1'b0;
    q_rd_addr    = enq_q;
    q_we         = '0;
    q_wr_addr    = enq_q;
    q_wr_head    = enq_t;
    q_wr_tail    = enq_t;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (in_data.opcode)
            OP_CREATE: begin
              if (can_queue) begin
                t_we.level   = 1'b1;
                t_we.quantum = 1'b1;
                t_wr_addr    = tid;
                t_wr_level   = lvl_sat;
                q_rd_en      = 1'b1;
                q_rd_addr    = home_new;
              end
            end
            OP_UNBLOCK: begin
              t_rd_en   = can_queue;
              t_rd_addr = tid;
            end
            OP_YIELD: t_rd_en = running_valid;
            OP_TICK:  t_rd_en = running_valid && mlfq_enable;
            default: ;
          endcase
        end
      end
      S_LVL: begin
        q_rd_en   = 1'b1;
        q_rd_addr = home_rd;
      end
      S_ENQ: begin
        if (nonempty[enq_q]) begin
          t_we.link  = 1'b1;
          t_wr_addr  = q_rd_tail;
          q_we.tail  = 1'b1;
        end else begin
          q_we.head  = 1'b1;
          q_we.tail  = 1'b1;
        end
      end
      S_DISP: begin
        q_rd_en   = disp_found;
        q_rd_addr = disp_q;
      end
      S_DP1: begin
        t_rd_en   = (q_rd_head != q_rd_tail);
        t_rd_addr = q_rd_head;
      end
      S_DP2: begin
        q_we.head = 1'b1;
        q_wr_addr = dq;
        q_wr_head = t_rd_link;
      end
      S_TICK: begin
        t_wr_addr = running_id;
        if (exhausted) begin
          t_we.level   = 1'b1;
          t_we.quantum = 1'b1;
          t_wr_level   = (t_rd_level != '0) ? t_rd_level - LW'(1) : t_rd_level;
        end else begin
          t_we.quantum = 1'b1;
          t_wr_quantum = qnt_inc;
        end
      end
      S_BST: begin
        q_rd_en   = nonempty[TOP];
        q_rd_addr = TOP;
      end
      S_BSTRD: begin
        q_rd_en   = nonempty[bq];
        q_rd_addr = bq;
      end
      S_BSTWR: begin
        // splice this level's list behind the top list
        t_we.link = tne;
        t_wr_addr = tt;
        t_wr_link = q_rd_head;
      end
      S_BSTEND: begin
        q_we.head = tne;
        q_we.tail = tne;
        q_wr_addr = TOP;
        q_wr_head = th;
        q_wr_tail = tt;
      end
      S_SWEEP: begin
        t_we.level = 1'b1;
        t_wr_addr  = sweep;
        t_wr_level = TOP;
      end
      default: ;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mlfq_enable  <= 1'b1;
      slice_ticks  <= SLICE_RESET;
      boost_period <= BOOST_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MLFQ_ENABLE:  mlfq_enable  <= cfg_data[0];
        CFG_SLICE_TICKS:  slice_ticks  <= cfg_data[3:0];
        CFG_BOOST_PERIOD: boost_period <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running_valid <= 1'b0;
      slice_count   <= '0;
      boost_count   <= '0;
      qvalid        <= '0;
      in_ready      <= '0;
      nonempty      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            preempt_r  <= 1'b0;
            demoted_r  <= 1'b0;
            boosted_r  <= 1'b0;
            do_boost   <= 1'b0;
            after_disp <= 1'b0;
            state      <= S_DONE;
            case (in_data.opcode)
              OP_CREATE: begin
                if (can_queue) begin
                  enq_t       <= tid;
                  enq_q       <= home_new;
                  qvalid[tid] <= 1'b1;
                  state       <= S_ENQ;
                end
              end
              OP_UNBLOCK: begin
                if (can_queue) begin
                  enq_t <= tid;
                  state <= S_LVL;
                end
              end
              OP_YIELD: begin
                enq_t      <= running_id;
                after_disp <= 1'b1;
                state      <= running_valid ? S_LVL : S_DISP;
              end
              OP_BLOCK: state <= S_DISP;
              OP_TICK: begin
                slice_count <= slice_inc;
                preempt_r   <= (slice_inc >= slice_ticks);
                if (mlfq_enable) begin
                  if (boost_inc >= boost_period) begin
                    boost_count <= '0;
                    boosted_r   <= 1'b1;
                    do_boost    <= 1'b1;
                  end else begin
                    boost_count <= boost_inc;
                  end
                  if (running_valid) state <= S_TICK;
                  else if (boost_inc >= boost_period) state <= S_BST;
                end
              end
              default: ;
            endcase
          end
        end
        S_LVL: begin
          enq_q <= home_rd;
          state <= S_ENQ;
        end
        S_ENQ: begin
          nonempty[enq_q] <= 1'b1;
          in_ready[enq_t] <= 1'b1;
          state           <= after_disp ? S_DISP : S_DONE;
        end
        S_DISP: begin
          slice_count <= '0;
          dq          <= disp_q;
          if (disp_found) begin
            state <= S_DP1;
          end else begin
            running_valid <= 1'b0;
            state         <= S_DONE;
          end
        end
        S_DP1: begin
          disp_t <= q_rd_head;
          if (q_rd_head == q_rd_tail) begin
            nonempty[dq]        <= 1'b0;
            in_ready[q_rd_head] <= 1'b0;
            running_valid       <= 1'b1;
            running_id          <= q_rd_head;
            state               <= S_DONE;
          end else begin
            state <= S_DP2;
          end
        end
        S_DP2: begin
          in_ready[disp_t] <= 1'b0;
          running_valid    <= 1'b1;
          running_id       <= disp_t;
          state            <= S_DONE;
        end
        S_TICK: begin
          qvalid[running_id] <= 1'b1;
          demoted_r          <= exhausted;
          state              <= do_boost ? S_BST : S_DONE;
        end
        S_BST: begin
          bq    <= TOP - LW'(1);
          state <= S_BSTA;
        end
        S_BSTA: begin
          th    <= q_rd_head;
          tt    <= q_rd_tail;
          tne   <= nonempty[TOP];
          state <= S_BSTRD;
        end
        S_BSTRD: begin
          if (nonempty[bq]) state <= S_BSTWR;
          else if (bq == '0) state <= S_BSTEND;
          else bq <= bq - LW'(1);
        end
        S_BSTWR: begin
          if (!tne) th <= q_rd_head;
          tt           <= q_rd_tail;
          tne          <= 1'b1;
          nonempty[bq] <= 1'b0;
          if (bq == '0) begin
            state <= S_BSTEND;
          end else begin
            bq    <= bq - LW'(1);
            state <= S_BSTRD;
          end
        end
        S_BSTEND: begin
          nonempty[TOP] <= tne;
          sweep         <= '0;
          state         <= S_SWEEP;
        end
        S_SWEEP: begin
          if (sweep == TW'(NUM_THREADS - 1)) state <= S_DONE;
          else sweep <= sweep + TW'(1);
        end
        S_DONE: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_data.next_thread <= running_valid ? 4'(running_id) : 4'd0;
      out_data.run_idle    <= !running_valid;
      out_data.preempt     <= preempt_r;
      out_data.demoted     <= demoted_r;
      out_data.boosted     <= boosted_r;
    end
  end

endmodule

// File: design/mlfqs_check.sv
// Port-level checks for the scheduler, bound to the top level.
module mlfqs_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_stall,
  input mlfqs_pkg::out_item_t             out_data
);
  import mlfqs_pkg::*;

  // idle shows thread zero
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.run_idle |-> out_data.next_thread == 4'd0)
    else $error("idle result with nonzero thread");

  // demotion only charges a running thread
  a_demote_running: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.demoted |-> !out_data.run_idle)
    else $error("demotion reported while idle");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind mlfq_thread_scheduler mlfqs_check u_mlfqs_check (.*);
